// ===== hw/rtl/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// shared types and codes for the keyboard matrix scanner
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam int unsigned MatrixDim = 8;
	localparam int unsigned JoyWidth  = 5;

	// access codes carried in the mode field
	localparam logic [2:0] MODE_KEY      = 3'd0;
	localparam logic [2:0] MODE_JOY_SET  = 3'd1;
	localparam logic [2:0] MODE_PAD_SET  = 3'd2;
	localparam logic [2:0] MODE_READ_ROW = 3'd3;
	localparam logic [2:0] MODE_READ_COL = 3'd4;
	localparam logic [2:0] MODE_READ_PAD = 3'd5;

	// port codes
	localparam logic [1:0] PORT_ONE = 2'd1;
	localparam logic [1:0] PORT_TWO = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [5:0] key_code;
		logic       key_down;
		logic [1:0] port;
		logic [7:0] joy_bits;
		logic [7:0] pad_x_in;
		logic [7:0] pad_y_in;
		logic [7:0] strobe_req;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic [7:0] pad_x_out;
		logic [7:0] pad_y_out;
	} result_t;

endpackage

// ===== hw/rtl/kms_in_stage.sv =====
// ----------------------------------------------------------------------------
// kms_in_stage
// input register and flow control for the scanner pipeline
// ----------------------------------------------------------------------------
module kms_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kms_pkg::item_t item,
	input  logic           out_free,
	output logic           advance,
	output kms_pkg::item_t item_s1
);

	logic valid_s1;

	// word moves on when the result register can take it
	assign advance  = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hw/rtl/kms_core.sv =====
// ----------------------------------------------------------------------------
// kms_core
// key matrix, joystick and paddle stores with their read logic
// ----------------------------------------------------------------------------
module kms_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  kms_pkg::item_t   item_s1,
	output kms_pkg::result_t result
);

	logic [kms_pkg::MatrixDim-1:0] key_matrix_q [kms_pkg::MatrixDim];
	logic [kms_pkg::JoyWidth-1:0]  joy_one_q;
	logic [kms_pkg::JoyWidth-1:0]  joy_two_q;
	logic [7:0]                    pad_x_q [2];
	logic [7:0]                    pad_y_q [2];

	logic       port_ok;
	logic       pad_idx;
	logic [2:0] key_col;
	logic [2:0] key_row;
	logic [7:0] row_hits;
	logic [7:0] col_hits;
	logic [7:0] active_rows;

	assign port_ok = (item_s1.port == kms_pkg::PORT_ONE) || (item_s1.port == kms_pkg::PORT_TWO);
	// port one maps to entry 0, port two to entry 1
	assign pad_idx = item_s1.port[1];
	assign key_col = item_s1.key_code[5:3];
	assign key_row = item_s1.key_code[2:0];
	assign active_rows = ~item_s1.strobe_req;

	always_comb begin
		row_hits = '0;
		col_hits = '0;
		for (int c = 0; c < kms_pkg::MatrixDim; c++) begin
			if (!item_s1.strobe_req[c]) begin
				row_hits = row_hits | key_matrix_q[c];
			end
			col_hits[c] = |(key_matrix_q[c] & active_rows);
		end
	end

	always_comb begin
		result = '0;
		unique case (item_s1.mode)
			kms_pkg::MODE_READ_ROW: begin
				result.read_value = ~row_hits & ~{3'b000, joy_one_q};
			end
			kms_pkg::MODE_READ_COL: begin
				result.read_value = ~col_hits & ~{3'b000, joy_two_q};
			end
			kms_pkg::MODE_READ_PAD: begin
				if (port_ok) begin
					result.pad_x_out = pad_x_q[pad_idx];
					result.pad_y_out = pad_y_q[pad_idx];
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < kms_pkg::MatrixDim; c++) begin
				key_matrix_q[c] <= '0;
			end
			joy_one_q  <= '0;
			joy_two_q  <= '0;
			pad_x_q[0] <= '0;
			pad_x_q[1] <= '0;
			pad_y_q[0] <= '0;
			pad_y_q[1] <= '0;
		end else if (advance) begin
			unique case (item_s1.mode)
				kms_pkg::MODE_KEY: begin
					key_matrix_q[key_col][key_row] <= item_s1.key_down;
				end
				kms_pkg::MODE_JOY_SET: begin
					if (item_s1.port == kms_pkg::PORT_ONE) begin
						joy_one_q <= item_s1.joy_bits[kms_pkg::JoyWidth-1:0];
					end else if (item_s1.port == kms_pkg::PORT_TWO) begin
						joy_two_q <= item_s1.joy_bits[kms_pkg::JoyWidth-1:0];
					end
				end
				kms_pkg::MODE_PAD_SET: begin
					if (port_ok) begin
						pad_x_q[pad_idx] <= item_s1.pad_x_in;
						pad_y_q[pad_idx] <= item_s1.pad_y_in;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/kms_out_stage.sv =====
// ----------------------------------------------------------------------------
// kms_out_stage
// result register with valid/stall handshake
// ----------------------------------------------------------------------------
module kms_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  kms_pkg::result_t result,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_stall,
	output kms_pkg::result_t result_s2
);

	assign out_free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== hw/rtl/keyboard_matrix_scanner_top.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_top
// 8x8 key matrix with joystick overlays and paddle pairs
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  input    in_valid / in_stall    mode key_code key_down port joy_bits
//                                  pad_x_in pad_y_in strobe_req
//  output   out_valid / out_stall  read_value pad_x_out pad_y_out
//
//  one word accepted per cycle while in_stall is low; a taken word sits in
//  the input register, and the store update/read logic feeds the result
//  register once that register is free
//  arst_n clears all key, joystick and paddle stores and both valid flags
//  out_stall backs up into in_stall only when both registers are full
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [5:0] key_code,
	input  logic       key_down,
	input  logic [1:0] port,
	input  logic [7:0] joy_bits,
	input  logic [7:0] pad_x_in,
	input  logic [7:0] pad_y_in,
	input  logic [7:0] strobe_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_value,
	output logic [7:0] pad_x_out,
	output logic [7:0] pad_y_out
);

	kms_pkg::item_t   item;
	kms_pkg::item_t   item_s1;
	kms_pkg::result_t result;
	kms_pkg::result_t result_s2;
	logic             advance;
	logic             out_free;

	// gather the input word
	assign item = '{
		mode:       mode,
		key_code:   key_code,
		key_down:   key_down,
		port:       port,
		joy_bits:   joy_bits,
		pad_x_in:   pad_x_in,
		pad_y_in:   pad_y_in,
		strobe_req: strobe_req
	};

	// input register and flow control
	kms_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.out_free (out_free),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	// stores are written as the word leaves the input register, so every
	// read sees all earlier writes in order
	kms_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	// result register
	kms_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_s2 (result_s2)
	);

	assign read_value = result_s2.read_value;
	assign pad_x_out  = result_s2.pad_x_out;
	assign pad_y_out  = result_s2.pad_y_out;

endmodule

// ===== hw/rtl/kms_checker.sv =====
// ----------------------------------------------------------------------------
// kms_checker
// port-level checks on the scanner's handshake and flow control
// ----------------------------------------------------------------------------
module kms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_value,
	input logic [7:0] pad_x_out,
	input logic [7:0] pad_y_out
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value)
			&& $stable(pad_x_out) && $stable(pad_y_out))
		else $error("stalled result word changed");

	// input is only held off when the result side is backed up
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

	// nothing comes out straight after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result word right after reset");

	// with the result side free, the input is never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is taken");

endmodule

bind keyboard_matrix_scanner_top kms_checker u_kms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.pad_x_out  (pad_x_out),
	.pad_y_out  (pad_y_out)
);

// ===== bench/keyboard_matrix_scanner_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_top_tb
// self-checking bench for the key matrix, joystick overlay and paddle block
// words go in through a bursty sender and come back through a receiver that
// stalls on its own pattern; a scoreboard keeps a copy of every store, works
// out the result of each accepted word and compares the results in order
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_top_tb;

	import kms_pkg::*;

	// codes the package leaves unnamed: spare modes and the dead ports
	localparam logic [2:0] MODE_UNUSED_A = 3'd6;
	localparam logic [2:0] MODE_UNUSED_B = 3'd7;
	localparam logic [1:0] PORT_NONE     = 2'd0;
	localparam logic [1:0] PORT_SPARE    = 2'd3;

	localparam int unsigned RANDOM_WORDS = 2000;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned LONG_HOLD    = 80;

	// ------------------------------------------------------------------------
	// scoreboard: mirror of the stores plus the queue of results still owed
	// ------------------------------------------------------------------------
	class matrix_scoreboard;
		logic [7:0]  key_cols [MatrixDim];
		logic [4:0]  joy_row_mask;
		logic [4:0]  joy_col_mask;
		logic [7:0]  pad_x [2];
		logic [7:0]  pad_y [2];
		result_t     due_results [$];
		int unsigned faults;

		function new();
			foreach (key_cols[c])
				key_cols[c] = '0;
			joy_row_mask = '0;
			joy_col_mask = '0;
			pad_x = '{8'h00, 8'h00};
			pad_y = '{8'h00, 8'h00};
			faults = 0;
		endfunction

		// apply one word to the mirrored stores and return what the block owes
		function result_t scan_outcome(item_t w);
			result_t r;
			logic [7:0] lines;
			int unsigned slot;
			r = '0;
			slot = (w.port == PORT_ONE) ? 0 : 1;
			case (w.mode)
				MODE_KEY: begin
					key_cols[w.key_code[5:3]][w.key_code[2:0]] = w.key_down;
				end
				MODE_JOY_SET: begin
					if (w.port == PORT_ONE)
						joy_row_mask = w.joy_bits[4:0];
					else if (w.port == PORT_TWO)
						joy_col_mask = w.joy_bits[4:0];
				end
				MODE_PAD_SET: begin
					if (w.port == PORT_ONE || w.port == PORT_TWO) begin
						pad_x[slot] = w.pad_x_in;
						pad_y[slot] = w.pad_y_in;
					end
				end
				MODE_READ_ROW: begin
					// selected columns pull their pressed rows low
					lines = 8'hFF;
					for (int c = 0; c < MatrixDim; c++)
						if (!w.strobe_req[c])
							lines &= ~key_cols[c];
					r.read_value = lines & ~{3'b000, joy_row_mask};
				end
				MODE_READ_COL: begin
					// a column goes low if any selected row holds a key in it
					lines = 8'hFF;
					for (int c = 0; c < MatrixDim; c++)
						if ((key_cols[c] & ~w.strobe_req) != 8'h00)
							lines[c] = 1'b0;
					r.read_value = lines & ~{3'b000, joy_col_mask};
				end
				MODE_READ_PAD: begin
					if (w.port == PORT_ONE || w.port == PORT_TWO) begin
						r.pad_x_out = pad_x[slot];
						r.pad_y_out = pad_y[slot];
					end
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_word(item_t w);
			due_results.push_back(scan_outcome(w));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result %h with no word outstanding", $time, got);
				faults++;
				return;
			end
			want = due_results.pop_front();
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value expected %02h got %02h",
					$time, want.read_value, got.read_value);
				faults++;
			end
			if (got.pad_x_out !== want.pad_x_out) begin
				$display("%0t: pad_x_out expected %02h got %02h",
					$time, want.pad_x_out, got.pad_x_out);
				faults++;
			end
			if (got.pad_y_out !== want.pad_y_out) begin
				$display("%0t: pad_y_out expected %02h got %02h",
					$time, want.pad_y_out, got.pad_y_out);
				faults++;
			end
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [2:0] mode       = MODE_KEY;
	logic [5:0] key_code   = '0;
	logic       key_down   = 1'b0;
	logic [1:0] port       = PORT_NONE;
	logic [7:0] joy_bits   = '0;
	logic [7:0] pad_x_in   = '0;
	logic [7:0] pad_y_in   = '0;
	logic [7:0] strobe_req = '0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] read_value;
	logic [7:0] pad_x_out;
	logic [7:0] pad_y_out;

	// set by the stimulus, taken and cleared by the receiver
	bit long_hold_req = 1'b0;

	matrix_scoreboard sb = new();

	keyboard_matrix_scanner_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key_code   (key_code),
		.key_down   (key_down),
		.port       (port),
		.joy_bits   (joy_bits),
		.pad_x_in   (pad_x_in),
		.pad_y_in   (pad_y_in),
		.strobe_req (strobe_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.pad_x_out  (pad_x_out),
		.pad_y_out  (pad_y_out)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------

	// offer one word from the falling edge and hold it until it is taken
	task automatic push_word(input item_t w);
		@(negedge clk);
		in_valid   <= 1'b1;
		mode       <= w.mode;
		key_code   <= w.key_code;
		key_down   <= w.key_down;
		port       <= w.port;
		joy_bits   <= w.joy_bits;
		pad_x_in   <= w.pad_x_in;
		pad_y_in   <= w.pad_y_in;
		strobe_req <= w.strobe_req;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(w);
	endtask

	// drop valid for a gap whose length n gives; zero means straight on
	task automatic hold_off(input int unsigned n);
		if (n == 0)
			return;
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic item_t word_of(logic [2:0] m, logic [5:0] code, logic dn,
		logic [1:0] p, logic [7:0] joy, logic [7:0] px, logic [7:0] py,
		logic [7:0] strobe);
		item_t w;
		w.mode       = m;
		w.key_code   = code;
		w.key_down   = dn;
		w.port       = p;
		w.joy_bits   = joy;
		w.pad_x_in   = px;
		w.pad_y_in   = py;
		w.strobe_req = strobe;
		return w;
	endfunction

	// mostly accesses that move state, with reads often enough to see it
	function automatic item_t random_word();
		item_t w;
		int unsigned pick;
		w.key_code   = 6'($urandom_range(0, 63));
		w.key_down   = ($urandom_range(0, 9) < 6);
		w.joy_bits   = 8'($urandom_range(0, 255));
		w.pad_x_in   = 8'($urandom_range(0, 255));
		w.pad_y_in   = 8'($urandom_range(0, 255));
		// dead ports now and then, the working pair most of the time
		if ($urandom_range(0, 4) == 0)
			w.port = $urandom_range(0, 1) ? PORT_SPARE : PORT_NONE;
		else
			w.port = $urandom_range(0, 1) ? PORT_TWO : PORT_ONE;
		case ($urandom_range(0, 3))
			0: w.strobe_req = 8'($urandom_range(0, 255));
			1: w.strobe_req = ~(8'h01 << $urandom_range(0, 7));
			2: w.strobe_req = $urandom_range(0, 3) ? 8'h00 : 8'hFF;
			default: w.strobe_req = 8'($urandom_range(0, 255)) | 8'($urandom_range(0, 255));
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 34)
			w.mode = MODE_KEY;
		else if (pick < 44)
			w.mode = MODE_JOY_SET;
		else if (pick < 52)
			w.mode = MODE_PAD_SET;
		else if (pick < 70)
			w.mode = MODE_READ_ROW;
		else if (pick < 88)
			w.mode = MODE_READ_COL;
		else if (pick < 97)
			w.mode = MODE_READ_PAD;
		else
			w.mode = $urandom_range(0, 1) ? MODE_UNUSED_B : MODE_UNUSED_A;
		// keep the joystick overlays quiet half the time so keys stay visible
		if (w.mode == MODE_JOY_SET && $urandom_range(0, 1))
			w.joy_bits[4:0] = '0;
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// main stimulus
	// ------------------------------------------------------------------------
	initial begin
		item_t       directed [$];
		item_t       w;
		int unsigned counted;
		int unsigned burst;
		bit          first_hold_done;
		bit          drain_done;
		bit          second_hold_done;

		counted = 0;
		first_hold_done = 0;
		drain_done = 0;
		second_hold_done = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner keys, then scans with every select, none and a single one
		directed.push_back(word_of(MODE_KEY, 6'o00, 1'b1, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_KEY, 6'o77, 1'b1, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_KEY, 6'o25, 1'b1, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_ROW, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_ROW, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'hFF));
		directed.push_back(word_of(MODE_READ_ROW, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h7F));
		directed.push_back(word_of(MODE_READ_COL, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_COL, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h7F));
		directed.push_back(word_of(MODE_READ_COL, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'hFF));
		// joystick writes: top bits dropped, dead ports ignored
		directed.push_back(word_of(MODE_JOY_SET, 6'o00, 1'b0, PORT_ONE, 8'hFF, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_JOY_SET, 6'o00, 1'b0, PORT_TWO, 8'hEA, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_JOY_SET, 6'o00, 1'b0, PORT_NONE, 8'h1F, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_JOY_SET, 6'o00, 1'b0, PORT_SPARE, 8'h1F, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_ROW, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'hFF));
		directed.push_back(word_of(MODE_READ_COL, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'hFE));
		// paddle pairs at their extremes, dead ports on write and read
		directed.push_back(word_of(MODE_PAD_SET, 6'o00, 1'b0, PORT_ONE, 8'h00, 8'hFF, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_PAD_SET, 6'o00, 1'b0, PORT_TWO, 8'h00, 8'h00, 8'hFF, 8'h00));
		directed.push_back(word_of(MODE_PAD_SET, 6'o00, 1'b0, PORT_SPARE, 8'h00, 8'h5A, 8'hA5, 8'h00));
		directed.push_back(word_of(MODE_PAD_SET, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'hA5, 8'h5A, 8'h00));
		directed.push_back(word_of(MODE_READ_PAD, 6'o00, 1'b0, PORT_ONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_PAD, 6'o00, 1'b0, PORT_TWO, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_PAD, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_PAD, 6'o00, 1'b0, PORT_SPARE, 8'h00, 8'h00, 8'h00, 8'h00));
		// spare modes, then a release seen through a full scan
		directed.push_back(word_of(MODE_UNUSED_A, 6'o77, 1'b1, PORT_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		directed.push_back(word_of(MODE_UNUSED_B, 6'o77, 1'b1, PORT_TWO, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		directed.push_back(word_of(MODE_KEY, 6'o77, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		directed.push_back(word_of(MODE_READ_ROW, 6'o00, 1'b0, PORT_NONE, 8'h00, 8'h00, 8'h00, 8'h00));
		foreach (directed[i])
			push_word(directed[i]);

		// random words in bursts with uneven gaps between them
		while (counted < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				w = random_word();
				push_word(w);
				if (w.mode != MODE_UNUSED_A && w.mode != MODE_UNUSED_B)
					counted++;
			end
			// the receiver holds off for a long stretch while words keep coming
			if ((counted >= RANDOM_WORDS / 4 && !first_hold_done) ||
				(counted >= 3 * RANDOM_WORDS / 4 && !second_hold_done)) begin
				long_hold_req = 1'b1;
				if (first_hold_done)
					second_hold_done = 1;
				first_hold_done = 1;
			end
			// once, let everything drain before going on
			if (counted >= RANDOM_WORDS / 2 && !drain_done) begin
				drain_done = 1;
				hold_off(1);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			// a quarter of bursts run straight into the next one
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 8));
		end

		// drain, then run on idle to catch anything extra
		hold_off(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.faults == 0)
			$display("[keyboard_matrix_scanner_top] OK");
		else
			$display("[keyboard_matrix_scanner_top] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver side: stall pattern changes style after a random run of cycles
	// ------------------------------------------------------------------------
	initial begin
		int unsigned hold_left;
		int unsigned style_left;
		int unsigned stall_style;
		hold_left = 0;
		style_left = 0;
		stall_style = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(16, 96);
			end
			style_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// results are taken on the rising edge, before anything there updates
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({read_value, pad_x_out, pad_y_out});
	end

	// watchdog, well above the slowest legal run
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[keyboard_matrix_scanner_top] ERROR");
		$finish;
	end

endmodule
